/* rtl/gprtas_pkg.sv */
// Shared constants, codes and types for the gamepad remap, turbo and analog scaler.
`timescale 1ns / 1ps

package gprtas_pkg;

    localparam int BUTTON_COUNT = 15;
    localparam int BTN_W        = 16;
    localparam int KEY_W        = 4;
    localparam int MAP_W        = KEY_W * BUTTON_COUNT;
    localparam int AXIS_W       = 8;
    localparam int GAIN_SHIFT   = 6;
    localparam logic [7:0] DUTY_MAX = 8'hFF;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 60;
    localparam int TDATA_W      = 48;

    typedef enum logic {
        OP_POLL = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_KEY   = 3'd0,
        CFG_DISABLE_KEY  = 3'd1,
        CFG_KEY_MAP      = 3'd2,
        CFG_ANALOG_FLAGS = 3'd3,
        CFG_RATIO_LEFT   = 3'd4,
        CFG_RATIO_RIGHT  = 3'd5,
        CFG_OFFSET_LEFT  = 3'd6,
        CFG_OFFSET_RIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_W-1:0] enable_key;
        logic [KEY_W-1:0] disable_key;
        logic             phase;
    } t_turbo_ctl;

endpackage

/* rtl/gprtas_axis.sv */
// One stick axis: gain by ratio/64 with floor, offset, clamp to 0..255.
`timescale 1ns / 1ps

module gprtas_axis (
    input  logic signed [8:0] i_axis,
    input  logic        [7:0] i_ratio,
    input  logic        [7:0] i_offset,
    output logic        [7:0] o_duty
);

    logic signed [17:0] prod;
    logic signed [11:0] scaled;
    logic signed [11:0] sum;

    always_comb begin
        prod   = 18'(i_axis) * 18'($signed({1'b0, i_ratio}));
        scaled = 12'(prod >>> gprtas_pkg::GAIN_SHIFT);
        sum    = scaled + $signed({4'b0, i_offset});
        if (sum < 0) begin
            o_duty = 8'd0;
        end else if (sum > $signed({4'b0, gprtas_pkg::DUTY_MAX})) begin
            o_duty = gprtas_pkg::DUTY_MAX;
        end else begin
            o_duty = sum[7:0];
        end
    end

endmodule

/* rtl/gprtas_btn.sv */
// Turbo latch update and button remap with turbo blanking, active-low result.
`timescale 1ns / 1ps

module gprtas_btn (
    input  logic [gprtas_pkg::BTN_W-1:0] i_held,
    input  logic [gprtas_pkg::BTN_W-1:0] i_latch,
    input  logic [gprtas_pkg::MAP_W-1:0] i_key_map,
    input  gprtas_pkg::t_turbo_ctl       i_ctl,
    output logic [gprtas_pkg::BTN_W-1:0] o_latch,
    output logic [gprtas_pkg::BTN_W-1:0] o_pin_levels
);

    logic [gprtas_pkg::BTN_W-1:0] scope;
    logic [gprtas_pkg::BTN_W-1:0] hit;
    logic                         en_hold;
    logic                         dis_hold;
    logic [gprtas_pkg::BTN_W-1:0] buttons;

    always_comb begin
        for (int p = 0; p < gprtas_pkg::BTN_W; p++) begin
            scope[p] = (p <= gprtas_pkg::BUTTON_COUNT)
                    && (gprtas_pkg::KEY_W'(p) != i_ctl.enable_key)
                    && (gprtas_pkg::KEY_W'(p) != i_ctl.disable_key);
        end
        hit      = i_held & scope;
        en_hold  = (i_ctl.enable_key != '0) && i_held[i_ctl.enable_key];
        dis_hold = (i_ctl.disable_key != '0) && i_held[i_ctl.disable_key];
        priority if (en_hold) begin
            o_latch = i_latch | hit;
        end else if (dis_hold) begin
            o_latch = i_latch & ~hit;
        end else begin
            o_latch = i_latch;
        end
    end

    // later held or blanked buttons mapped to the same position win
    always_comb begin
        for (int p = 0; p < gprtas_pkg::BTN_W; p++) begin
            buttons[p] = 1'b0;
            for (int i = 0; i < gprtas_pkg::BUTTON_COUNT; i++) begin
                if (i_key_map[gprtas_pkg::KEY_W*i +: gprtas_pkg::KEY_W]
                        == gprtas_pkg::KEY_W'(p)) begin
                    if (i_held[i+1]) begin
                        buttons[p] = 1'b1;
                    end
                    if (i_ctl.phase && o_latch[i+1]) begin
                        buttons[p] = 1'b0;
                    end
                end
            end
        end
        o_pin_levels = ~buttons;
    end

endmodule

/* rtl/gamepad_remap_turbo_analog_scaler.sv */
// Top level of the gamepad remap, turbo and analog scaler.
// Takes one word per clock and passes a poll result from the input register to the
// result register; throughput is one word per cycle unless a poll word waits behind
// an unaccepted result, set by the single input and result registers with the remap
// and four 9x9 multiplies between them. A tick word toggles the turbo phase and gives
// no result; the result register lets a new word enter while a finished result waits.
`timescale 1ns / 1ps

module gamepad_remap_turbo_analog_scaler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gprtas_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gprtas_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // held_buttons[15:0], left_x[23:16], left_y[31:24], right_x[39:32], right_y[47:40]
    input  logic [gprtas_pkg::TDATA_W-1:0]       s_axis_tdata,
    // operation[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pin_levels[15:0], duty_lx[23:16], duty_ly[31:24], duty_rx[39:32], duty_ry[47:40]
    output logic [gprtas_pkg::TDATA_W-1:0]       m_axis_tdata
);

    logic [gprtas_pkg::KEY_W-1:0]  r_enable_key;
    logic [gprtas_pkg::KEY_W-1:0]  r_disable_key;
    logic [gprtas_pkg::MAP_W-1:0]  r_key_map;
    logic [2:0]                    r_flags;
    logic [7:0]                    r_ratio_l;
    logic [7:0]                    r_ratio_r;
    logic [7:0]                    r_offset_l;
    logic [7:0]                    r_offset_r;

    logic [gprtas_pkg::BTN_W-1:0]  r_latch;
    logic                          r_phase;

    logic                          r_in_vld;
    gprtas_pkg::t_op               r_in_op;
    logic [gprtas_pkg::TDATA_W-1:0] r_in_data;

    logic                          r_out_vld;
    logic [gprtas_pkg::TDATA_W-1:0] r_out_data;

    logic                          s1_go;
    logic                          out_load;
    logic                          n_out_vld;
    gprtas_pkg::t_turbo_ctl        ctl;
    logic [gprtas_pkg::BTN_W-1:0]  n_latch;
    logic [gprtas_pkg::BTN_W-1:0]  pin_levels;
    logic signed [8:0]             ax_lx, ax_ly, ax_rx, ax_ry;
    logic signed [8:0]             sw_lx, sw_ly, sw_rx, sw_ry;
    logic [7:0]                    duty_lx, duty_ly, duty_rx, duty_ry;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_key  <= '0;
            r_disable_key <= '0;
            r_key_map     <= '0;
            r_flags       <= '0;
            r_ratio_l     <= 8'd64;
            r_ratio_r     <= 8'd64;
            r_offset_l    <= 8'd128;
            r_offset_r    <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (gprtas_pkg::t_cfg_idx'(i_cfg_idx))
                gprtas_pkg::CFG_ENABLE_KEY:   r_enable_key  <= i_cfg_wdata[3:0];
                gprtas_pkg::CFG_DISABLE_KEY:  r_disable_key <= i_cfg_wdata[3:0];
                gprtas_pkg::CFG_KEY_MAP:      r_key_map     <= i_cfg_wdata;
                gprtas_pkg::CFG_ANALOG_FLAGS: r_flags       <= i_cfg_wdata[2:0];
                gprtas_pkg::CFG_RATIO_LEFT:   r_ratio_l     <= i_cfg_wdata[7:0];
                gprtas_pkg::CFG_RATIO_RIGHT:  r_ratio_r     <= i_cfg_wdata[7:0];
                gprtas_pkg::CFG_OFFSET_LEFT:  r_offset_l    <= i_cfg_wdata[7:0];
                gprtas_pkg::CFG_OFFSET_RIGHT: r_offset_r    <= i_cfg_wdata[7:0];
            endcase
        end
    end

    // handshake
    always_comb begin
        s1_go = r_in_vld && ((r_in_op == gprtas_pkg::OP_TICK) || !r_out_vld || m_axis_tready);
        out_load = s1_go && (r_in_op == gprtas_pkg::OP_POLL);
        s_axis_tready = !r_in_vld || s1_go;
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= gprtas_pkg::t_op'(s_axis_tuser);
            r_in_data <= s_axis_tdata;
        end
    end

    // buttons and turbo
    assign ctl = '{enable_key: r_enable_key, disable_key: r_disable_key, phase: r_phase};

    gprtas_btn u_btn (
        .i_held       (r_in_data[15:0]),
        .i_latch      (r_latch),
        .i_key_map    (r_key_map),
        .i_ctl        (ctl),
        .o_latch      (n_latch),
        .o_pin_levels (pin_levels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            r_phase <= 1'b0;
        end else if (s1_go) begin
            if (r_in_op == gprtas_pkg::OP_TICK) begin
                r_phase <= !r_phase;
            end else begin
                r_latch <= n_latch;
            end
        end
    end

    // axes: swap, then negate
    always_comb begin
        ax_lx = {r_in_data[23], r_in_data[23:16]};
        ax_ly = {r_in_data[31], r_in_data[31:24]};
        ax_rx = {r_in_data[39], r_in_data[39:32]};
        ax_ry = {r_in_data[47], r_in_data[47:40]};
        if (r_flags[0]) begin
            sw_lx = ax_rx;
            sw_ly = ax_ry;
            sw_rx = ax_lx;
            sw_ry = ax_ly;
        end else begin
            sw_lx = ax_lx;
            sw_ly = ax_ly;
            sw_rx = ax_rx;
            sw_ry = ax_ry;
        end
        if (r_flags[1]) begin
            sw_lx = 9'sd0 - sw_lx;
            sw_rx = 9'sd0 - sw_rx;
        end
        if (r_flags[2]) begin
            sw_ly = 9'sd0 - sw_ly;
            sw_ry = 9'sd0 - sw_ry;
        end
    end

    gprtas_axis u_lx (.i_axis(sw_lx), .i_ratio(r_ratio_l), .i_offset(r_offset_l), .o_duty(duty_lx));
    gprtas_axis u_ly (.i_axis(sw_ly), .i_ratio(r_ratio_l), .i_offset(r_offset_l), .o_duty(duty_ly));
    gprtas_axis u_rx (.i_axis(sw_rx), .i_ratio(r_ratio_r), .i_offset(r_offset_r), .o_duty(duty_rx));
    gprtas_axis u_ry (.i_axis(sw_ry), .i_ratio(r_ratio_r), .i_offset(r_offset_r), .o_duty(duty_ry));

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {duty_ry, duty_rx, duty_ly, duty_lx, pin_levels};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_tick_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in_op == gprtas_pkg::OP_TICK) |=> (r_phase != $past(r_phase)))
        else $error("tick did not toggle turbo phase");

    a_tick_keeps_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in_op == gprtas_pkg::OP_TICK) |=> $stable(r_latch))
        else $error("tick changed turbo latches");

    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in_op == gprtas_pkg::OP_TICK)
            |=> (r_out_vld == ($past(r_out_vld) && !$past(m_axis_tready))))
        else $error("tick produced a result word");

    a_stall_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld && !m_axis_tready))
        else $error("input stalled without a blocked result");

endmodule

/* dv/pad_result_checker.sv */
// Result checker for the gamepad scaler: tracks registers and turbo state, predicts each poll.
`timescale 1ns / 1ps

module pad_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gprtas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gprtas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [gprtas_pkg::TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [gprtas_pkg::TDATA_W-1:0]      m_axis_tdata,
    output int                                  o_errors,
    output int                                  o_pending
);

    typedef struct packed {
        logic [7:0]                   duty_ry;
        logic [7:0]                   duty_rx;
        logic [7:0]                   duty_ly;
        logic [7:0]                   duty_lx;
        logic [gprtas_pkg::BTN_W-1:0] pin_levels;
    } t_pad_out;

    logic [gprtas_pkg::KEY_W-1:0] enable_key;
    logic [gprtas_pkg::KEY_W-1:0] disable_key;
    logic [gprtas_pkg::MAP_W-1:0] key_map;
    logic [2:0]                   analog_flags;
    logic [7:0]                   ratio_left;
    logic [7:0]                   ratio_right;
    logic [7:0]                   offset_left;
    logic [7:0]                   offset_right;
    logic [gprtas_pkg::BTN_W-1:0] turbo_latches;
    logic                         blink_phase;
    t_pad_out                     pending_results[$];

    function automatic logic [7:0] axis_duty(int v, logic [7:0] ratio, logic [7:0] offset);
        int r;
        r = ((v * int'(ratio)) >>> gprtas_pkg::GAIN_SHIFT) + int'(offset);
        if (r < 0) r = 0;
        if (r > int'(gprtas_pkg::DUTY_MAX)) r = int'(gprtas_pkg::DUTY_MAX);
        return r[7:0];
    endfunction

    // Advance turbo latches and build the expected result of one poll word.
    function automatic t_pad_out predict_poll(logic [gprtas_pkg::TDATA_W-1:0] word);
        logic [gprtas_pkg::BTN_W-1:0] held;
        logic [gprtas_pkg::BTN_W-1:0] buttons;
        logic [gprtas_pkg::KEY_W-1:0] pos;
        int                           lx, ly, rx, ry, t;
        t_pad_out                     res;
        held = word[gprtas_pkg::BTN_W-1:0];
        if (enable_key != 0 && held[enable_key]) begin
            for (int i = 0; i <= gprtas_pkg::BUTTON_COUNT; i++) begin
                if (i != enable_key && i != disable_key && held[i]) turbo_latches[i] = 1'b1;
            end
        end else if (disable_key != 0 && held[disable_key]) begin
            for (int i = 0; i <= gprtas_pkg::BUTTON_COUNT; i++) begin
                if (i != enable_key && i != disable_key && held[i]) turbo_latches[i] = 1'b0;
            end
        end
        buttons = '0;
        for (int i = 0; i < gprtas_pkg::BUTTON_COUNT; i++) begin
            pos = key_map[gprtas_pkg::KEY_W*i +: gprtas_pkg::KEY_W];
            if (held[i+1]) buttons[pos] = 1'b1;
            if (blink_phase && turbo_latches[i+1]) buttons[pos] = 1'b0;
        end
        lx = $signed(word[23:16]);
        ly = $signed(word[31:24]);
        rx = $signed(word[39:32]);
        ry = $signed(word[47:40]);
        if (analog_flags[0]) begin
            t = lx; lx = rx; rx = t;
            t = ly; ly = ry; ry = t;
        end
        if (analog_flags[1]) begin
            lx = -lx;
            rx = -rx;
        end
        if (analog_flags[2]) begin
            ly = -ly;
            ry = -ry;
        end
        res.pin_levels = ~buttons;
        res.duty_lx    = axis_duty(lx, ratio_left, offset_left);
        res.duty_ly    = axis_duty(ly, ratio_left, offset_left);
        res.duty_rx    = axis_duty(rx, ratio_right, offset_right);
        res.duty_ry    = axis_duty(ry, ratio_right, offset_right);
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pad_out want;
        t_pad_out got;
        if (!i_rst_n) begin
            enable_key    = '0;
            disable_key   = '0;
            key_map       = '0;
            analog_flags  = '0;
            ratio_left    = 8'd64;
            ratio_right   = 8'd64;
            offset_left   = 8'd128;
            offset_right  = 8'd128;
            turbo_latches = '0;
            blink_phase   = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (gprtas_pkg::t_cfg_idx'(i_cfg_idx))
                    gprtas_pkg::CFG_ENABLE_KEY:
                        enable_key   = i_cfg_wdata[gprtas_pkg::KEY_W-1:0];
                    gprtas_pkg::CFG_DISABLE_KEY:
                        disable_key  = i_cfg_wdata[gprtas_pkg::KEY_W-1:0];
                    gprtas_pkg::CFG_KEY_MAP:
                        key_map      = i_cfg_wdata[gprtas_pkg::MAP_W-1:0];
                    gprtas_pkg::CFG_ANALOG_FLAGS: analog_flags = i_cfg_wdata[2:0];
                    gprtas_pkg::CFG_RATIO_LEFT:   ratio_left   = i_cfg_wdata[7:0];
                    gprtas_pkg::CFG_RATIO_RIGHT:  ratio_right  = i_cfg_wdata[7:0];
                    gprtas_pkg::CFG_OFFSET_LEFT:  offset_left  = i_cfg_wdata[7:0];
                    gprtas_pkg::CFG_OFFSET_RIGHT: offset_right = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_results.size() == 0) begin
                    $error("unexpected result word %h", m_axis_tdata);
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("pin_levels", want.pin_levels, got.pin_levels);
                    check_field("duty_lx", 16'(want.duty_lx), 16'(got.duty_lx));
                    check_field("duty_ly", 16'(want.duty_ly), 16'(got.duty_ly));
                    check_field("duty_rx", 16'(want.duty_rx), 16'(got.duty_rx));
                    check_field("duty_ry", 16'(want.duty_ry), 16'(got.duty_ry));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (gprtas_pkg::t_op'(s_axis_tuser) == gprtas_pkg::OP_TICK) begin
                    blink_phase = ~blink_phase;
                end else begin
                    pending_results.push_back(predict_poll(s_axis_tdata));
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

/* dv/testbench.sv */
// Testbench top for the gamepad scaler: clock, reset, register writes, words and verdict.
`timescale 1ns / 1ps

module testbench;

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [gprtas_pkg::CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [gprtas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata   = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [gprtas_pkg::TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                                s_axis_tuser  = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [gprtas_pkg::TDATA_W-1:0]      m_axis_tdata;

    int                           error_count;
    int                           results_owed;
    int                           burst_left  = 0;
    bit                           hold_req    = 1'b0;
    bit                           hold_active = 1'b0;
    logic [gprtas_pkg::KEY_W-1:0] cur_enable  = '0;
    logic [gprtas_pkg::KEY_W-1:0] cur_disable = '0;

    gamepad_remap_turbo_analog_scaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pad_result_checker u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (error_count),
        .o_pending     (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stall the result side on random patterns, or hold off for a long stretch on request.
    initial begin
        int mode;
        int span;
        forever begin
            if (hold_req) begin
                hold_active = 1'b1;
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span) begin
                    @(posedge i_clk);
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(gprtas_pkg::t_cfg_idx idx,
                             logic [gprtas_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_word(gprtas_pkg::t_op op, logic [15:0] held, logic [7:0] lx,
                             logic [7:0] ly, logic [7:0] rx, logic [7:0] ry);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ry, rx, ly, lx, held};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for every result, then let a trailing tick word drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        wait (results_owed == 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h40;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_axis();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [gprtas_pkg::MAP_W-1:0] map;
        bit                           collide;
        cur_enable  = 4'($urandom_range(0, 15));
        cur_disable = 4'($urandom_range(0, 15));
        collide     = 1'($urandom_range(0, 1));
        for (int i = 0; i < gprtas_pkg::BUTTON_COUNT; i++) begin
            map[gprtas_pkg::KEY_W*i +: gprtas_pkg::KEY_W] =
                collide ? 4'($urandom_range(0, 3)) : 4'($urandom);
        end
        write_reg(gprtas_pkg::CFG_ENABLE_KEY, gprtas_pkg::CFG_DATA_W'(cur_enable));
        write_reg(gprtas_pkg::CFG_DISABLE_KEY, gprtas_pkg::CFG_DATA_W'(cur_disable));
        write_reg(gprtas_pkg::CFG_KEY_MAP, gprtas_pkg::CFG_DATA_W'(map));
        write_reg(gprtas_pkg::CFG_ANALOG_FLAGS,
                  gprtas_pkg::CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(gprtas_pkg::CFG_RATIO_LEFT, gprtas_pkg::CFG_DATA_W'(pick_byte()));
        write_reg(gprtas_pkg::CFG_RATIO_RIGHT, gprtas_pkg::CFG_DATA_W'(pick_byte()));
        write_reg(gprtas_pkg::CFG_OFFSET_LEFT, gprtas_pkg::CFG_DATA_W'(pick_byte()));
        write_reg(gprtas_pkg::CFG_OFFSET_RIGHT, gprtas_pkg::CFG_DATA_W'(pick_byte()));
    endtask

    task automatic random_words(int count);
        logic [15:0] held;
        repeat (count) begin
            held = 16'($urandom);
            case ($urandom_range(0, 4))
                0: held[cur_enable] = 1'b1;
                1: held[cur_disable] = 1'b1;
                2: held = held & 16'($urandom);
                default: ;
            endcase
            if ($urandom_range(0, 4) == 0) begin
                send_word(gprtas_pkg::OP_TICK, held,
                          pick_axis(), pick_axis(), pick_axis(), pick_axis());
            end else begin
                send_word(gprtas_pkg::OP_POLL, held,
                          pick_axis(), pick_axis(), pick_axis(), pick_axis());
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(gprtas_pkg::OP_POLL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_POLL, 16'hFFFF, 8'h7F, 8'h7F, 8'h80, 8'h80);
        send_word(gprtas_pkg::OP_TICK, 16'hFFFF, 8'h80, 8'h80, 8'h80, 8'h80);
        send_word(gprtas_pkg::OP_POLL, 16'hAAAA, 8'h80, 8'h7F, 8'h01, 8'hFF);
        settle();

        // enable key only, bit 0 stays out of the latches
        write_reg(gprtas_pkg::CFG_ENABLE_KEY, gprtas_pkg::CFG_DATA_W'(1));
        write_reg(gprtas_pkg::CFG_KEY_MAP, 60'hFED_CBA9_8765_4321);
        send_word(gprtas_pkg::OP_POLL, 16'h00F3, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_POLL, 16'h00FF, 8'h01, 8'hFF, 8'h40, 8'hC0);
        settle();

        // both keys set: enable wins, disable clears
        write_reg(gprtas_pkg::CFG_ENABLE_KEY, gprtas_pkg::CFG_DATA_W'(2));
        write_reg(gprtas_pkg::CFG_DISABLE_KEY, gprtas_pkg::CFG_DATA_W'(15));
        send_word(gprtas_pkg::OP_POLL, 16'h0005, 8'h10, 8'hF0, 8'h20, 8'hE0);
        send_word(gprtas_pkg::OP_POLL, 16'h8104, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_POLL, 16'h8101, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_POLL, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();

        // all buttons on one position, negate both axes, extreme gains and offsets
        write_reg(gprtas_pkg::CFG_KEY_MAP, 60'h777_7777_7777_7777);
        write_reg(gprtas_pkg::CFG_ANALOG_FLAGS, gprtas_pkg::CFG_DATA_W'(6));
        write_reg(gprtas_pkg::CFG_RATIO_LEFT, gprtas_pkg::CFG_DATA_W'(255));
        write_reg(gprtas_pkg::CFG_RATIO_RIGHT, gprtas_pkg::CFG_DATA_W'(0));
        write_reg(gprtas_pkg::CFG_OFFSET_LEFT, gprtas_pkg::CFG_DATA_W'(0));
        write_reg(gprtas_pkg::CFG_OFFSET_RIGHT, gprtas_pkg::CFG_DATA_W'(255));
        send_word(gprtas_pkg::OP_POLL, 16'hFFFF, 8'h80, 8'h80, 8'h80, 8'h80);
        send_word(gprtas_pkg::OP_POLL, 16'h5555, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
        send_word(gprtas_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(gprtas_pkg::OP_POLL, 16'hFFFF, 8'h01, 8'hFF, 8'h80, 8'h7F);
        settle();

        // swap sticks, tiny left gain rounds toward minus infinity
        write_reg(gprtas_pkg::CFG_KEY_MAP, 60'h012_3456_789A_BCDE);
        write_reg(gprtas_pkg::CFG_ANALOG_FLAGS, gprtas_pkg::CFG_DATA_W'(1));
        write_reg(gprtas_pkg::CFG_RATIO_LEFT, gprtas_pkg::CFG_DATA_W'(1));
        write_reg(gprtas_pkg::CFG_RATIO_RIGHT, gprtas_pkg::CFG_DATA_W'(128));
        write_reg(gprtas_pkg::CFG_OFFSET_LEFT, gprtas_pkg::CFG_DATA_W'(128));
        write_reg(gprtas_pkg::CFG_OFFSET_RIGHT, gprtas_pkg::CFG_DATA_W'(0));
        send_word(gprtas_pkg::OP_POLL, 16'h7FFE, 8'hFF, 8'h01, 8'h80, 8'h7F);
        send_word(gprtas_pkg::OP_POLL, 16'h8001, 8'h80, 8'h7F, 8'hFF, 8'h01);
        settle();

        for (int p = 0; p < 8; p++) begin
            random_config();
            if (p == 4) begin
                hold_req = 1'b1;
                wait (hold_active);
            end
            random_words(90);
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && results_owed == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
